### sv/icpc_pkg.sv
// ----------------------------------------------------------------------------
// icpc_pkg: shared types and constants for the colour conversion pipeline
// Request and result formats, fixed-point constants, stage counts of the
// square root and power units, and elaboration-time helpers.
// ----------------------------------------------------------------------------
package icpc_pkg;

  typedef logic signed [23:0] pix_t;

  typedef struct packed {
    logic cmd;
    pix_t red;
    pix_t green;
    pix_t blue;
    pix_t orig_red;
    pix_t orig_green;
    pix_t orig_blue;
    logic was_in_gamut;
  } req_t;

  typedef struct packed {
    pix_t out_red;
    pix_t out_green;
    pix_t out_blue;
    logic gamut_ok;
    logic passed_through;
  } rsp_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_FWD_ROW0 = 3'd0,
    REG_FWD_ROW1 = 3'd1,
    REG_FWD_ROW2 = 3'd2,
    REG_INV_ROW0 = 3'd3,
    REG_INV_ROW1 = 3'd4,
    REG_INV_ROW2 = 3'd5,
    REG_MODE     = 3'd6
  } reg_idx_t;

  // Commands
  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_INV = 1'b1;

  // How a channel's curve result is formed
  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_LIN  = 2'd1,
    KIND_POW  = 2'd2
  } kind_t;

  localparam logic [47:0] ROW0_RST = 48'd4096;
  localparam logic [47:0] ROW1_RST = 48'd4096 << 16;
  localparam logic [47:0] ROW2_RST = 48'd4096 << 32;

  localparam int SQRT_LAT = 20;
  localparam int POW_LAT  = 44;

  localparam logic [17:0] EXP_ENC   = 18'd27307;
  localparam logic [17:0] EXP_DEC   = 18'd157286;
  localparam logic [22:0] PIX_MAX_U = 23'h7FFFFF;

  // Clamp a wide signed value to the pixel range
  function automatic pix_t sat_pix(logic signed [47:0] x);
    pix_t r;
    if (x > 48'sd8388607) r = 24'sh7FFFFF;
    else if (x < -48'sd8388608) r = 24'sh800000;
    else r = x[23:0];
    return r;
  endfunction

  // Matrix coefficient j of a packed row
  function automatic logic signed [15:0] coef(logic [47:0] row, int unsigned j);
    return row[16*j +: 16];
  endfunction

  // Floor square root, evaluated on constants only
  function automatic logic [63:0] isqrt_c(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] b;
    r = '0;
    rem = x;
    for (int i = 31; i >= 0; i--) begin
      b = (r << (i + 1)) + (64'd1 << (2 * i));
      if (rem >= b) begin
        rem = rem - b;
        r = r | (64'd1 << i);
      end
    end
    return r;
  endfunction

  // Q30 factor 2^(2^-i) as a chain of floor square roots
  function automatic logic [31:0] exp_factor(int i);
    logic [63:0] t;
    t = 64'd1 << 31;
    for (int j = 1; j <= i; j++) begin
      t = isqrt_c(t << 30);
    end
    return t[31:0];
  endfunction

endpackage

### sv/icpc_sqrt.sv
// ----------------------------------------------------------------------------
// icpc_sqrt: pipelined integer square root
// Floor square root of a 40-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module icpc_sqrt import icpc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [39:0] x,
  output logic [19:0] root
);

  logic [40:0] rem_q  [SQRT_LAT];
  logic [19:0] root_q [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    localparam int I = SQRT_LAT - 1 - k;
    logic [40:0] rem_in;
    logic [19:0] root_in;
    logic [40:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, x};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Trial subtract for this root bit
    assign trial = ({21'b0, root_in} << (I + 1)) + (41'd1 << (2 * I));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (20'd1 << I);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root = root_q[SQRT_LAT-1];

endmodule

### sv/icpc_pow.sv
// ----------------------------------------------------------------------------
// icpc_pow: pipelined fixed-point power
// u^k for positive Q16 u with k the encode or decode exponent: log2 by
// repeated squaring, one multiply by k, exp2 as a product of root factors.
// ----------------------------------------------------------------------------
module icpc_pow import icpc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [22:0] u,
  input  logic        dec,
  output logic [22:0] p
);

  localparam int NLOG = 20;
  localparam int NEXP = 20;

  // Normalize: leading one position and Q30 mantissa
  logic [4:0]        pos;
  logic [30:0]       m0;
  logic signed [5:0] li0;
  logic              dec0;

  always_comb begin
    pos = '0;
    for (int b = 0; b < 23; b++) begin
      if (u[b]) pos = 5'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0   <= {8'b0, u} << (5'd30 - pos);
      li0  <= $signed({1'b0, pos}) - 6'sd16;
      dec0 <= dec;
    end
  end

  // Log2 fraction, one bit per squaring stage
  logic [30:0]       lm [NLOG];
  logic [19:0]       lf [NLOG];
  logic signed [5:0] li [NLOG];
  logic              ld [NLOG];

  for (genvar j = 0; j < NLOG; j++) begin : g_log
    localparam int I = NLOG - 1 - j;
    logic [30:0]       m_in;
    logic [19:0]       f_in;
    logic signed [5:0] i_in;
    logic              d_in;
    logic [61:0]       sq;
    logic [31:0]       mm;

    if (j == 0) begin : g_first
      assign m_in = m0;
      assign f_in = '0;
      assign i_in = li0;
      assign d_in = dec0;
    end else begin : g_next
      assign m_in = lm[j-1];
      assign f_in = lf[j-1];
      assign i_in = li[j-1];
      assign d_in = ld[j-1];
    end

    assign sq = 62'(m_in) * 62'(m_in);
    assign mm = sq[61:30];

    always_ff @(posedge clk) begin
      if (en) begin
        if (mm[31]) begin
          lm[j] <= mm[31:1];
          lf[j] <= f_in | (20'd1 << I);
        end else begin
          lm[j] <= mm[30:0];
          lf[j] <= f_in;
        end
        li[j] <= i_in;
        ld[j] <= d_in;
      end
    end
  end

  // Scale the log by the exponent
  logic signed [25:0] lg;
  logic signed [44:0] yp;
  logic signed [44:0] y;
  logic signed [44:0] e;
  logic [19:0]        f0;
  logic signed [9:0]  s0;

  assign lg = {li[NLOG-1], lf[NLOG-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      yp <= 45'(lg) * $signed({27'b0, (ld[NLOG-1] ? EXP_DEC : EXP_ENC)});
    end
  end

  assign y = (yp + 45'sd32768) >>> 16;
  assign e = y >>> 20;

  always_ff @(posedge clk) begin
    if (en) begin
      f0 <= y[19:0];
      s0 <= 10'(e) - 10'sd14;
    end
  end

  // Exp2 of the fraction, one conditional factor per stage
  logic [31:0]       xa [NEXP];
  logic [19:0]       xf [NEXP];
  logic signed [9:0] xs [NEXP];

  for (genvar i = 0; i < NEXP; i++) begin : g_exp
    localparam logic [31:0] TI = exp_factor(i + 1);
    logic [31:0]       a_in;
    logic [19:0]       f_in;
    logic signed [9:0] s_in;
    logic [63:0]       prod;

    if (i == 0) begin : g_first
      assign a_in = 32'd1 << 30;
      assign f_in = f0;
      assign s_in = s0;
    end else begin : g_next
      assign a_in = xa[i-1];
      assign f_in = xf[i-1];
      assign s_in = xs[i-1];
    end

    assign prod = 64'(a_in) * 64'(TI) + (64'd1 << 29);

    always_ff @(posedge clk) begin
      if (en) begin
        xa[i] <= f_in[NEXP-1-i] ? prod[61:30] : a_in;
        xf[i] <= f_in;
        xs[i] <= s_in;
      end
    end
  end

  // Final scaling by 2^s with rounding and clamp
  logic [31:0]       acc;
  logic signed [9:0] s;
  logic [9:0]        n;
  logic [39:0]       lsh;
  logic [40:0]       rsh;
  logic [22:0]       p_next;

  assign acc = xa[NEXP-1];
  assign s   = xs[NEXP-1];
  assign n   = 10'(-s);

  always_comb begin
    lsh    = {8'b0, acc} << s[3:0];
    rsh    = ({9'b0, acc} + (41'd1 << (n[5:0] - 6'd1))) >> n[5:0];
    p_next = '0;
    if (s > 10'sd8) begin
      p_next = PIX_MAX_U;
    end else if (s >= 10'sd0) begin
      p_next = (lsh > 40'(PIX_MAX_U)) ? PIX_MAX_U : lsh[22:0];
    end else if (n <= 10'd40) begin
      p_next = (rsh > 41'(PIX_MAX_U)) ? PIX_MAX_U : rsh[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) p <= p_next;
  end

endmodule

### sv/inference_colour_pre_post_convert.sv
// ----------------------------------------------------------------------------
// inference_colour_pre_post_convert: per-pixel colour conversion pipeline
// Forward: matrix and gamut flag in profile mode, optional square root, sRGB encode.
// Inverse: sRGB decode, optional square, inverse matrix in profile mode, pass-through.
// One pixel per cycle sustained while the result is not held by rsp_stall.
// The depth comes from the 20-stage square root and the 44-stage power unit
// (20 squarings for log2, 20 factors for exp2), with a bubble-free stall.
// Reset clears all valid bits, loads identity matrices and clears mode.
// ----------------------------------------------------------------------------
module inference_colour_pre_post_convert import icpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  typedef struct packed {
    logic              valid;
    req_t              req;
    logic              gok;
    logic [2:0][23:0]  w;
    logic [2:0][41:0]  dp;
  } pre_t;

  typedef struct packed {
    logic             valid;
    req_t             req;
    logic             gok;
    kind_t [2:0]      kind;
    logic [2:0][23:0] lin;
  } post_t;

  // Configuration registers
  logic [47:0] fwd_row [3];
  logic [47:0] inv_row [3];
  logic [3:0]  mode;
  logic        prof, boost, keep, up;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_row[0] <= ROW0_RST;
      fwd_row[1] <= ROW1_RST;
      fwd_row[2] <= ROW2_RST;
      inv_row[0] <= ROW0_RST;
      inv_row[1] <= ROW1_RST;
      inv_row[2] <= ROW2_RST;
      mode       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FWD_ROW0: fwd_row[0] <= cfg_data;
        REG_FWD_ROW1: fwd_row[1] <= cfg_data;
        REG_FWD_ROW2: fwd_row[2] <= cfg_data;
        REG_INV_ROW0: inv_row[0] <= cfg_data;
        REG_INV_ROW1: inv_row[1] <= cfg_data;
        REG_INV_ROW2: inv_row[2] <= cfg_data;
        REG_MODE:     mode       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign prof  = mode[0];
  assign boost = mode[1];
  assign keep  = mode[2];
  assign up    = mode[3];

  // Advance the whole pipeline unless the result is held
  logic en;
  assign en        = !rsp_valid || !rsp_stall;
  assign req_stall = !en;

  // Stage 1: capture request
  logic v1;
  req_t r1;
  pix_t px1 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (en) r1 <= req;
  end

  assign px1[0] = r1.red;
  assign px1[1] = r1.green;
  assign px1[2] = r1.blue;

  // Stage 2: forward matrix products
  logic               v2;
  req_t               r2;
  logic signed [39:0] fp2 [3][3];
  pix_t               px2 [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2 <= r1;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          fp2[r][c] <= coef(fwd_row[r], c) * px1[c];
        end
      end
    end
  end

  assign px2[0] = r2.red;
  assign px2[1] = r2.green;
  assign px2[2] = r2.blue;

  // Stage 3: row sums, round and clamp; bypass without profile
  logic v3;
  req_t r3;
  pix_t w3 [3];
  pix_t px3 [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    logic signed [47:0] sum;
    if (en) begin
      r3 <= r2;
      for (int r = 0; r < 3; r++) begin
        sum = 48'(fp2[r][0]) + 48'(fp2[r][1]) + 48'(fp2[r][2]);
        w3[r] <= prof ? sat_pix((sum + 48'sd2048) >>> 12) : px2[r];
      end
    end
  end

  assign px3[0] = r3.red;
  assign px3[1] = r3.green;
  assign px3[2] = r3.blue;

  // Stage 4: gamut flag, root operand, decode pre-scale product
  pre_t        d4_next;
  pre_t        d4;
  logic [39:0] x4 [3];

  always_comb begin
    logic signed [41:0] t;
    d4_next       = '0;
    d4_next.valid = v3;
    d4_next.req   = r3;
    d4_next.gok   = prof;
    for (int c = 0; c < 3; c++) begin
      if (w3[c] < -24'sd655 || w3[c] > 24'sd66191) d4_next.gok = 1'b0;
      d4_next.w[c] = w3[c];
      t = 42'(px3[c]) + 42'sd3604;
      d4_next.dp[c] = t * 42'sd62119;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) d4.valid <= 1'b0;
    else if (en) d4 <= d4_next;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        x4[c] <= (w3[c] > 24'sd0) ? {1'b0, w3[c][22:0], 16'b0} : '0;
      end
    end
  end

  // Square root units and matching delay line
  logic [19:0] root24 [3];
  pre_t        dl1 [SQRT_LAT];

  for (genvar c = 0; c < 3; c++) begin : g_sqrt
    icpc_sqrt u_sqrt (
      .clk  (clk),
      .en   (en),
      .x    (x4[c]),
      .root (root24[c])
    );
  end

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_dl1
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) dl1[k].valid <= 1'b0;
        else if (en) dl1[k] <= d4;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) dl1[k].valid <= 1'b0;
        else if (en) dl1[k] <= dl1[k-1];
      end
    end
  end

  // Stage 25: power operand, curve segment and linear segment value
  pre_t        a24;
  post_t       d25_next;
  post_t       d25;
  logic [22:0] u25_next [3];
  logic [22:0] u25 [3];
  pix_t        px24 [3];

  assign a24     = dl1[SQRT_LAT-1];
  assign px24[0] = a24.req.red;
  assign px24[1] = a24.req.green;
  assign px24[2] = a24.req.blue;

  always_comb begin
    pix_t               w;
    pix_t               v;
    logic signed [41:0] b;
    logic [31:0]        lf;
    d25_next       = '0;
    d25_next.valid = a24.valid;
    d25_next.req   = a24.req;
    d25_next.gok   = a24.gok;
    for (int c = 0; c < 3; c++) begin
      w = a24.w[c];
      if (boost) v = (w > 24'sd0) ? pix_t'({4'b0, root24[c]}) : '0;
      else v = w;
      b = ($signed(a24.dp[c]) + 42'sd32768) >>> 16;
      if (a24.req.cmd == CMD_FWD) begin
        u25_next[c] = v[22:0];
        lf = (32'(v[7:0]) * 32'd846725 + 32'd32768) >> 16;
        if (v <= 24'sd0) d25_next.kind[c] = KIND_ZERO;
        else if (v <= 24'sd205) d25_next.kind[c] = KIND_LIN;
        else d25_next.kind[c] = KIND_POW;
      end else begin
        u25_next[c] = b[22:0];
        lf = (32'(px24[c][11:0]) * 32'd5072 + 32'd32768) >> 16;
        if (px24[c] <= 24'sd0) d25_next.kind[c] = KIND_ZERO;
        else if (px24[c] <= 24'sd2651) d25_next.kind[c] = KIND_LIN;
        else d25_next.kind[c] = KIND_POW;
      end
      d25_next.lin[c] = lf[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) d25.valid <= 1'b0;
    else if (en) d25 <= d25_next;
  end

  always_ff @(posedge clk) begin
    if (en) u25 <= u25_next;
  end

  // Power units and matching delay line
  logic [22:0] p69 [3];
  post_t       dl2 [POW_LAT];

  for (genvar c = 0; c < 3; c++) begin : g_pow
    icpc_pow u_pow (
      .clk (clk),
      .en  (en),
      .u   (u25[c]),
      .dec (d25.req.cmd),
      .p   (p69[c])
    );
  end

  for (genvar k = 0; k < POW_LAT; k++) begin : g_dl2
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) dl2[k].valid <= 1'b0;
        else if (en) dl2[k] <= d25;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) dl2[k].valid <= 1'b0;
        else if (en) dl2[k] <= dl2[k-1];
      end
    end
  end

  // Stage 70: encode gain product
  post_t       d70;
  logic [22:0] p70 [3];
  logic [39:0] gp70 [3];

  always_ff @(posedge clk) begin
    if (rst) d70.valid <= 1'b0;
    else if (en) d70 <= dl2[POW_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        p70[c]  <= p69[c];
        gp70[c] <= 40'(p69[c]) * 40'd69140;
      end
    end
  end

  // Stage 71: pick zero, linear or curve result
  post_t d71;
  pix_t  w71 [3];

  always_ff @(posedge clk) begin
    if (rst) d71.valid <= 1'b0;
    else if (en) d71 <= d70;
  end

  always_ff @(posedge clk) begin
    logic signed [47:0] g;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        g = $signed({8'b0, gp70[c]});
        case (d70.kind[c])
          KIND_ZERO: w71[c] <= '0;
          KIND_LIN:  w71[c] <= d70.lin[c];
          default: begin
            if (d70.req.cmd == CMD_FWD) w71[c] <= sat_pix(((g + 48'sd32768) >>> 16) - 48'sd3604);
            else w71[c] <= pix_t'({1'b0, p70[c]});
          end
        endcase
      end
    end
  end

  // Stage 72: boost square product
  post_t       d72;
  pix_t        w72 [3];
  logic [45:0] sq72 [3];

  always_ff @(posedge clk) begin
    if (rst) d72.valid <= 1'b0;
    else if (en) d72 <= d71;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        w72[c]  <= w71[c];
        sq72[c] <= 46'(w71[c][22:0]) * 46'(w71[c][22:0]);
      end
    end
  end

  // Stage 73: round and clamp the square on the inverse path
  post_t d73;
  pix_t  w73 [3];

  always_ff @(posedge clk) begin
    if (rst) d73.valid <= 1'b0;
    else if (en) d73 <= d72;
  end

  always_ff @(posedge clk) begin
    logic [45:0] q;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        q = (sq72[c] + 46'd32768) >> 16;
        if (d72.req.cmd == CMD_INV && boost) w73[c] <= sat_pix($signed({2'b0, q}));
        else w73[c] <= w72[c];
      end
    end
  end

  // Stage 74: inverse matrix products
  post_t              d74;
  pix_t               w74 [3];
  logic signed [39:0] ip74 [3][3];

  always_ff @(posedge clk) begin
    if (rst) d74.valid <= 1'b0;
    else if (en) d74 <= d73;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w74 <= w73;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          ip74[r][c] <= coef(inv_row[r], c) * w73[c];
        end
      end
    end
  end

  // Stage 75: inverse matrix sums, pass-through, result register
  rsp_t rsp_next;
  pix_t org74 [3];
  pix_t res [3];

  assign org74[0] = d74.req.orig_red;
  assign org74[1] = d74.req.orig_green;
  assign org74[2] = d74.req.orig_blue;

  always_comb begin
    logic signed [47:0] sum;
    logic               pt;
    logic               gok;
    pt  = 1'b0;
    gok = 1'b0;
    for (int c = 0; c < 3; c++) begin
      sum = 48'(ip74[c][0]) + 48'(ip74[c][1]) + 48'(ip74[c][2]);
      if (d74.req.cmd == CMD_FWD) begin
        res[c] = w74[c];
        gok    = d74.gok;
      end else if (prof) begin
        if (keep && !up && !d74.req.was_in_gamut) begin
          res[c] = org74[c];
          pt     = 1'b1;
        end else begin
          res[c] = sat_pix((sum + 48'sd2048) >>> 12);
        end
      end else if (keep && !up && (org74[c] < 24'sd0 || org74[c] > 24'sd65536)) begin
        res[c] = org74[c];
        pt     = 1'b1;
      end else begin
        res[c] = w74[c];
      end
    end
    rsp_next.out_red        = res[0];
    rsp_next.out_green      = res[1];
    rsp_next.out_blue       = res[2];
    rsp_next.gamut_ok       = gok;
    rsp_next.passed_through = pt;
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (en) rsp_valid <= d74.valid;
  end

  always_ff @(posedge clk) begin
    if (en) rsp <= rsp_next;
  end

  // A forward result never passes through; an inverse one is never in gamut
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.gamut_ok && rsp.passed_through))
    else $error("gamut_ok and passed_through both set");

  // A request in stage 3 reaches stage 4 on the next advance
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (en && v3) |=> d4.valid)
    else $error("request lost between stage 3 and stage 4");

  // A held pipeline keeps its first stage
  a_hold_stage1: assert property (@(posedge clk) disable iff (rst)
    !en |=> (v1 == $past(v1)))
    else $error("stage 1 changed while held");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

### sim/icpc_checker.sv
// ----------------------------------------------------------------------------
// icpc_checker: scoreboard for the colour conversion pipeline
// Mirrors the configuration port, predicts each accepted request in fixed
// point and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module icpc_checker import icpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0] fwd_mat [3];
  logic [47:0] inv_mat [3];
  logic [3:0]  mode_q;
  rsp_t        expected_px [$];

  initial errors = 0;
  assign pending = expected_px.size();

  function automatic longint clamp_pix(longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  function automatic bit [63:0] sqrt_floor(bit [63:0] x);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // u^k with u and k in Q16, through log2 and exp2
  function automatic longint pow_q16(longint u, longint k);
    bit [63:0] uu;
    bit [63:0] m;
    bit [63:0] t;
    bit [63:0] acc;
    int p;
    longint lg, y, e, f, s;
    uu = u;
    p = 63;
    while (p > 0 && uu[p] == 1'b0) p--;
    if (p > 30) m = uu >> (p - 30);
    else m = uu << (30 - p);
    lg = longint'(p - 16) * (64'sd1 << 20);
    for (int i = 19; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        lg += 64'sd1 << i;
      end
    end
    y = (lg * k + 64'sd32768) >>> 16;
    e = y >>> 20;
    f = y - e * (64'sd1 << 20);
    acc = 64'd1 << 30;
    t = 64'd1 << 31;
    for (int i = 1; i <= 20; i++) begin
      t = sqrt_floor(t << 30);
      if (f[20 - i]) acc = (acc * t + (64'd1 << 29)) >> 30;
    end
    s = e - 14;
    if (s >= 0) begin
      if (s > 8) return 64'sd8388607;
      return clamp_pix(longint'(acc << s));
    end
    if (-s > 40) return 0;
    return clamp_pix(longint'((acc + (64'd1 << (-s - 1))) >> (-s)));
  endfunction

  function automatic longint srgb_encode(longint v);
    longint p;
    if (v <= 0) return 0;
    if (v <= 205) return clamp_pix((v * 846725 + 32768) >>> 16);
    p = pow_q16(v, longint'(EXP_ENC));
    return clamp_pix(((p * 69140 + 32768) >>> 16) - 3604);
  endfunction

  function automatic longint srgb_decode(longint v);
    longint b;
    if (v <= 0) return 0;
    if (v <= 2651) return clamp_pix((v * 5072 + 32768) >>> 16);
    b = ((v + 3604) * 62119 + 32768) >>> 16;
    if (b <= 0) return 0;
    return pow_q16(b, longint'(EXP_DEC));
  endfunction

  function automatic longint mat_row(logic [47:0] row, longint x0, longint x1, longint x2);
    longint acc;
    acc = longint'($signed(row[15:0])) * x0 + longint'($signed(row[31:16])) * x1
        + longint'($signed(row[47:32])) * x2;
    return clamp_pix((acc + 2048) >>> 12);
  endfunction

  // Expected result of one pixel request under the current registers
  function automatic rsp_t convert_pixel(req_t r);
    longint px [3];
    longint org [3];
    longint w [3];
    longint res [3];
    logic prof, boost, keep, up, gok, pt;
    rsp_t o;
    prof = mode_q[0];
    boost = mode_q[1];
    keep = mode_q[2];
    up = mode_q[3];
    gok = 1'b0;
    pt = 1'b0;
    px[0] = r.red; px[1] = r.green; px[2] = r.blue;
    org[0] = r.orig_red; org[1] = r.orig_green; org[2] = r.orig_blue;
    if (r.cmd == CMD_FWD) begin
      if (prof) begin
        for (int c = 0; c < 3; c++) w[c] = mat_row(fwd_mat[c], px[0], px[1], px[2]);
        gok = 1'b1;
        for (int c = 0; c < 3; c++)
          if (w[c] < -655 || w[c] > 65536 + 655) gok = 1'b0;
      end else begin
        for (int c = 0; c < 3; c++) w[c] = px[c];
      end
      for (int c = 0; c < 3; c++) begin
        if (boost) w[c] = (w[c] > 0) ? longint'(sqrt_floor(64'(w[c]) << 16)) : 0;
        res[c] = srgb_encode(w[c]);
      end
    end else begin
      for (int c = 0; c < 3; c++) begin
        w[c] = srgb_decode(px[c]);
        if (boost) w[c] = clamp_pix((w[c] * w[c] + 32768) >>> 16);
      end
      if (prof) begin
        if (keep && !up && !r.was_in_gamut) begin
          for (int c = 0; c < 3; c++) res[c] = org[c];
          pt = 1'b1;
        end else begin
          for (int c = 0; c < 3; c++) res[c] = mat_row(inv_mat[c], w[0], w[1], w[2]);
        end
      end else begin
        for (int c = 0; c < 3; c++) begin
          if (keep && !up && (org[c] < 0 || org[c] > 65536)) begin
            res[c] = org[c];
            pt = 1'b1;
          end else begin
            res[c] = w[c];
          end
        end
      end
    end
    o.out_red = res[0][23:0];
    o.out_green = res[1][23:0];
    o.out_blue = res[2][23:0];
    o.gamut_ok = gok;
    o.passed_through = pt;
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Mirror register writes
  always @(posedge clk) begin
    if (rst) begin
      fwd_mat[0] <= ROW0_RST; fwd_mat[1] <= ROW1_RST; fwd_mat[2] <= ROW2_RST;
      inv_mat[0] <= ROW0_RST; inv_mat[1] <= ROW1_RST; inv_mat[2] <= ROW2_RST;
      mode_q <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index)) inside
        REG_FWD_ROW0, REG_FWD_ROW1, REG_FWD_ROW2: begin
          fwd_mat[cfg_index[1:0]] <= cfg_data;
        end
        REG_INV_ROW0, REG_INV_ROW1, REG_INV_ROW2: begin
          inv_mat[2'(cfg_index - REG_INV_ROW0)] <= cfg_data;
        end
        REG_MODE: begin
          mode_q <= cfg_data[3:0];
        end
        default: ;
      endcase
    end
  end

  // Predict accepted requests, compare accepted results
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && req_valid && !req_stall) expected_px.push_back(convert_pixel(req));
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_px.size() == 0) begin
        errors++;
        $display("[%0t] result with no request outstanding", $time);
      end else begin
        want = expected_px.pop_front();
        if (rsp.out_red !== want.out_red) report("out_red", rsp.out_red, want.out_red);
        if (rsp.out_green !== want.out_green)
          report("out_green", rsp.out_green, want.out_green);
        if (rsp.out_blue !== want.out_blue) report("out_blue", rsp.out_blue, want.out_blue);
        if (rsp.gamut_ok !== want.gamut_ok) report("gamut_ok", rsp.gamut_ok, want.gamut_ok);
        if (rsp.passed_through !== want.passed_through)
          report("passed_through", rsp.passed_through, want.passed_through);
      end
    end
  end

endmodule

### sim/tb_inference_colour_pre_post_convert.sv
// ----------------------------------------------------------------------------
// tb_inference_colour_pre_post_convert: testbench for the colour pipeline
// Runs directed corner pixels, then random pixels over a sequence of matrix
// and mode settings with random gaps on both channels; a checker compares.
// ----------------------------------------------------------------------------
module tb_inference_colour_pre_post_convert import icpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES     = 12;
  localparam int PER_PHASE  = 140;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          rsp_took = 1'b0;
  bit          no_gaps = 1'b0;

  logic [3:0] phase_mode [PHASES] = '{4'd5, 4'd0, 4'd1, 4'd3, 4'd7, 4'd13, 4'd4, 4'd6,
                                      4'd2, 4'd15, 4'd9, 4'd12};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  inference_colour_pre_post_convert DUT (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
  );

  icpc_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .errors, .pending
  );

  // Note each accepted result
  always @(posedge clk) begin
    rsp_took <= rsp_valid && !rsp_stall;
  end

  // Stall the result side for a random count after each accepted result
  always @(negedge clk) begin
    if (rsp_took) stall_left = no_gaps ? 0 : $urandom_range(0, 6);
    if (stall_left > 0) begin
      rsp_stall = 1'b1;
      stall_left--;
    end else begin
      rsp_stall = 1'b0;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || rst || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** inference_colour_pre_post_convert: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [47:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Hold the request until accepted; leave valid high for back-to-back
  task automatic send_pixel(req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = r;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic pix_t rand_pix();
    pix_t corner [10] = '{24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd1, -24'sd1, 24'sd205,
                          24'sd206, 24'sd2651, 24'sd2652, 24'sd65536};
    case ($urandom_range(0, 9)) inside
      0, 1: return pix_t'($urandom());
      2: return corner[$urandom_range(0, 9)];
      default: return pix_t'(int'($urandom_range(0, 24'h16000)) - 24'h1000);
    endcase
  endfunction

  function automatic logic [47:0] rand_row(int kind, int r);
    logic [47:0] row;
    case (kind)
      0: row = 48'd4096 << (16 * r);
      1: begin
        for (int j = 0; j < 3; j++)
          row[16*j +: 16] = 16'(int'($urandom_range(0, 16384)) - 8192);
      end
      2: row = 48'({$urandom(), $urandom()});
      default: row = $urandom_range(0, 1) ? {3{16'h7FFF}} : {3{16'h8000}};
    endcase
    return row;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.cmd = 1'($urandom_range(0, 1));
    r.red = rand_pix();
    r.green = rand_pix();
    r.blue = rand_pix();
    r.orig_red = rand_pix();
    r.orig_green = rand_pix();
    r.orig_blue = rand_pix();
    r.was_in_gamut = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t mk_req(logic cmd, pix_t r, pix_t g, pix_t b, pix_t o, logic wg);
    req_t q;
    q = '{cmd, r, g, b, o, -o, 24'sd32768, wg};
    return q;
  endfunction

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      // Reprogram only while the pipe is empty
      for (int r = 0; r < 3; r++) begin
        write_reg(reg_idx_t'(REG_FWD_ROW0 + r), rand_row(p % 4, r));
        write_reg(reg_idx_t'(REG_INV_ROW0 + r), rand_row((p + 1) % 4, r));
      end
      write_reg(REG_MODE, {44'd0, phase_mode[p]});
      no_gaps = (p % 3 == 2);
      if (p == 0) begin
        // Corner pixels: knees, gamut margin edges, extremes, pass-through
        send_pixel(mk_req(CMD_FWD, 24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd0, 1'b1));
        send_pixel(mk_req(CMD_FWD, 24'sd205, 24'sd206, 24'sd1, 24'sd0, 1'b1));
        send_pixel(mk_req(CMD_FWD, 24'sd66191, 24'sd0, 24'sd0, 24'sd0, 1'b1));
        send_pixel(mk_req(CMD_FWD, 24'sd66192, 24'sd0, 24'sd0, 24'sd0, 1'b1));
        send_pixel(mk_req(CMD_FWD, -24'sd655, 24'sd65536, 24'sd100, 24'sd0, 1'b1));
        send_pixel(mk_req(CMD_FWD, -24'sd656, 24'sd65536, 24'sd100, 24'sd0, 1'b1));
        send_pixel(mk_req(CMD_FWD, -24'sd1, 24'sd32768, 24'sd65535, 24'sd0, 1'b0));
        send_pixel(mk_req(CMD_INV, 24'sd2651, 24'sd2652, 24'sd0, 24'sd100, 1'b1));
        send_pixel(mk_req(CMD_INV, 24'sh7FFFFF, 24'sh800000, 24'sd65536, 24'sd5, 1'b1));
        send_pixel(mk_req(CMD_INV, 24'sd30000, 24'sd40000, 24'sd50000, 24'sh7FFFFF, 1'b0));
        send_pixel(mk_req(CMD_INV, 24'sd30000, 24'sd1, -24'sd1, 24'sh800000, 1'b0));
        send_pixel(mk_req(CMD_INV, 24'sd65536, 24'sd20000, 24'sd3000, 24'sd65537, 1'b1));
        drain();
        write_reg(REG_MODE, {44'd0, 4'd4});
        send_pixel(mk_req(CMD_INV, 24'sd30000, 24'sd2652, 24'sd1, 24'sd65537, 1'b0));
        send_pixel(mk_req(CMD_INV, 24'sd30000, 24'sd2652, 24'sd1, -24'sd1, 1'b1));
        send_pixel(mk_req(CMD_INV, 24'sd30000, 24'sd2652, 24'sd1, 24'sd65536, 1'b1));
        drain();
        write_reg(REG_MODE, {44'd0, 4'd2});
        send_pixel(mk_req(CMD_FWD, 24'sh7FFFFF, 24'sd1, -24'sd5, 24'sd0, 1'b1));
        send_pixel(mk_req(CMD_INV, 24'sh7FFFFF, 24'sd2652, 24'sd65536, 24'sd0, 1'b1));
        drain();
        write_reg(REG_MODE, {44'd0, phase_mode[p]});
      end
      repeat (PER_PHASE) send_pixel(rand_req());
      drain();
    end
    if (errors == 0) begin
      $display("** inference_colour_pre_post_convert: PASSED **");
    end else begin
      $display("** inference_colour_pre_post_convert: FAILED **");
    end
    $finish;
  end

endmodule
